FILE: rtl/core/mains_phase_lock_period_pi_defines.svh
// Assertion macros shared by the phase lock modules.
`ifndef MAINS_PHASE_LOCK_PERIOD_PI_DEFINES_SVH
`define MAINS_PHASE_LOCK_PERIOD_PI_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MPLPI_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MPLPI_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/mplpi_pkg.sv
// Types and constants of the mains phase lock period adjuster.
package mplpi_pkg;

    localparam int unsigned P_W     = 24;  // nominal period
    localparam int unsigned CAPT_W  = 25;  // captured timer count
    localparam int unsigned ERR_W   = 26;  // folded phase error
    localparam int unsigned ADJ_W   = 25;  // adjusted period
    localparam int unsigned INTEG_W = 36;  // error integral
    localparam int unsigned DVD_W   = 36;  // divider dividend
    localparam int unsigned DVS_W   = 24;  // divider divisor
    localparam int unsigned KDIV_W  = 16;  // P/400
    localparam int unsigned DLIM_W  = 18;  // P/120
    localparam int unsigned Q1_W    = 25;  // integral / 1000, signed
    localparam int unsigned QE_W    = 26;  // -err / (P/400), signed
    localparam int unsigned QQ_W    = 25;  // (integral/1000) / (P/400), signed
    localparam int unsigned DELTA_W = 27;

    localparam logic [P_W-1:0]     PERIOD_RESET = 24'd160000;
    localparam logic [KDIV_W-1:0]  KDIV_RESET   = 16'd400;
    localparam logic [DLIM_W-1:0]  DLIM_RESET   = 18'd1333;
    localparam logic [INTEG_W-1:0] LIM_RESET    = 36'd160000000;

    localparam logic [DVS_W-1:0] GAIN_DIV  = 24'd400;
    localparam logic [DVS_W-1:0] LIMIT_DIV = 24'd120;
    localparam logic [DVS_W-1:0] INTEG_DIV = 24'd1000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRE400,
        S_PRE120,
        S_INTEG,
        S_CLAMP,
        S_DIVI,
        S_DIVE,
        S_DIVQ,
        S_SUM,
        S_LIMIT,
        S_RESULT
    } seq_state_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DVD_W-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic signed [ERR_W-1:0] phase_error;
        logic                    period_updated;
        logic [ADJ_W-1:0]        adjusted_period;
    } result_t;

endpackage

FILE: rtl/core/mplpi_serdiv.sv
// Restoring unsigned divider, one quotient bit per cycle.
`include "mains_phase_lock_period_pi_defines.svh"

module mplpi_serdiv
(
    input  logic               clk,
    input  logic               rst_n,
    input  mplpi_pkg::div_req_t req,
    output mplpi_pkg::div_rsp_t rsp
);

    localparam int unsigned W     = mplpi_pkg::DVD_W;
    localparam int unsigned D     = mplpi_pkg::DVS_W;
    localparam int unsigned CNT_W = $clog2(W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(W - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [D-1:0]     rem_reg, rem_next;
    logic [D-1:0]     dvs_reg, dvs_next;

    logic [D:0] shifted;
    logic [D:0] diff;
    logic       ge;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        ge        = !diff[D];
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract where it fits
            rem_next = ge ? diff[D-1:0] : shifted[D-1:0];
            quo_next = {quo_reg[W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    `MPLPI_ASSERT_IMP(a_start_idle, req.start, !busy_reg, "divider started while busy")
    `MPLPI_ASSERT_NXT(a_finish, busy_reg && cnt_reg == LAST && !req.start, done_reg && !busy_reg, "divider did not finish on its last bit")

endmodule

FILE: rtl/core/mplpi_seq.sv
// Sequencer and state of the phase lock: fold, integrate, PI update.
`include "mains_phase_lock_period_pi_defines.svh"

module mplpi_seq #(
    parameter int unsigned UPDATE_EVERY = 10
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mplpi_pkg::P_W-1:0]           cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [mplpi_pkg::CAPT_W-1:0]        capt,
    output logic                                res_valid,
    input  logic                                res_ready,
    output mplpi_pkg::result_t                  res,
    output mplpi_pkg::div_req_t                 div_req,
    input  mplpi_pkg::div_rsp_t                 div_rsp
);

    localparam int unsigned P_W     = mplpi_pkg::P_W;
    localparam int unsigned CAPT_W  = mplpi_pkg::CAPT_W;
    localparam int unsigned ERR_W   = mplpi_pkg::ERR_W;
    localparam int unsigned ADJ_W   = mplpi_pkg::ADJ_W;
    localparam int unsigned INTEG_W = mplpi_pkg::INTEG_W;
    localparam int unsigned KDIV_W  = mplpi_pkg::KDIV_W;
    localparam int unsigned DLIM_W  = mplpi_pkg::DLIM_W;
    localparam int unsigned Q1_W    = mplpi_pkg::Q1_W;
    localparam int unsigned QE_W    = mplpi_pkg::QE_W;
    localparam int unsigned QQ_W    = mplpi_pkg::QQ_W;
    localparam int unsigned DELTA_W = mplpi_pkg::DELTA_W;
    localparam int unsigned CNT_W   = $clog2(UPDATE_EVERY + 1);
    localparam logic [CNT_W-1:0] UE_C = CNT_W'(UPDATE_EVERY);

    mplpi_pkg::seq_state_t state_reg, state_next;

    logic [P_W-1:0]      p_reg, p_next;
    logic [ADJ_W-1:0]    period_reg, period_next;
    logic [INTEG_W-1:0]  lim_reg, lim_next;
    logic [KDIV_W-1:0]   kdiv_reg, kdiv_next;
    logic [DLIM_W-1:0]   dlim_reg, dlim_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic signed [INTEG_W-1:0] integ_reg, integ_next;

    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic signed [INTEG_W-1:0] sum_reg, sum_next;
    logic signed [Q1_W-1:0]    q1_reg, q1_next;
    logic signed [QE_W-1:0]    qe_reg, qe_next;
    logic signed [QQ_W-1:0]    qq_reg, qq_next;
    logic signed [DELTA_W-1:0] delta_reg, delta_next;
    logic                      upd_reg, upd_next;

    logic                      in_fire;
    logic                      cfg_fire;
    logic                      fold;
    logic signed [ERR_W-1:0]   err_in;
    logic [CNT_W-1:0]          cnt_inc;
    logic signed [INTEG_W-1:0] lim_s;
    logic signed [INTEG_W-1:0] nlim_s;
    logic signed [INTEG_W-1:0] sum_neg;
    logic                      over;
    logic                      under;
    logic [INTEG_W-1:0]        integ_abs;
    logic [ERR_W-1:0]          err_abs;
    logic [Q1_W-1:0]           q1_abs;
    logic [mplpi_pkg::DVD_W-1:0] quo;
    logic signed [DELTA_W-1:0] dlim_s;
    logic signed [DELTA_W-1:0] delta_clamp;
    logic [DELTA_W-1:0]        period_sum;
    logic [INTEG_W-1:0]        cfg_p_ext;

    assign cfg_ready = (state_reg == mplpi_pkg::S_IDLE);
    assign in_ready  = (state_reg == mplpi_pkg::S_IDLE) && !cfg_valid;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_fire   = in_valid && in_ready;
    assign res_valid = (state_reg == mplpi_pkg::S_RESULT);

    assign res.phase_error     = err_reg;
    assign res.period_updated  = upd_reg;
    assign res.adjusted_period = period_reg;

    assign quo = div_rsp.quotient;

    always_comb
    begin
        // error is minus the capture; fold by one period past half a period
        fold   = capt > {2'b00, p_reg[P_W-1:1]};
        err_in = fold ? ({2'b00, p_reg} - {1'b0, capt}) : -{1'b0, capt};

        cnt_inc = cnt_reg + 1'b1;

        lim_s   = lim_reg;
        nlim_s  = -lim_reg;
        sum_neg = -sum_reg;
        over    = sum_reg > lim_s;
        under   = sum_reg < nlim_s;
        integ_abs = (over || under) ? lim_reg
                                    : (sum_reg[INTEG_W-1] ? sum_neg : sum_reg);

        err_abs = err_reg[ERR_W-1] ? -err_reg : err_reg;
        q1_abs  = q1_reg[Q1_W-1] ? -q1_reg : q1_reg;

        dlim_s      = {{(DELTA_W-DLIM_W){1'b0}}, dlim_reg};
        delta_clamp = (delta_reg > dlim_s) ? dlim_s
                    : ((delta_reg < -dlim_s) ? -dlim_s : delta_reg);
        period_sum  = {{(DELTA_W-P_W){1'b0}}, p_reg} + delta_clamp;

        // P * 1000 as shifts
        cfg_p_ext = {{(INTEG_W-P_W){1'b0}}, cfg_data};

        state_next  = state_reg;
        p_next      = p_reg;
        period_next = period_reg;
        lim_next    = lim_reg;
        kdiv_next   = kdiv_reg;
        dlim_next   = dlim_reg;
        cnt_next    = cnt_reg;
        integ_next  = integ_reg;
        err_next    = err_reg;
        sum_next    = sum_reg;
        q1_next     = q1_reg;
        qe_next     = qe_reg;
        qq_next     = qq_reg;
        delta_next  = delta_reg;
        upd_next    = upd_reg;

        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;

        unique case (state_reg)
            mplpi_pkg::S_IDLE:
            begin
                if (cfg_fire)
                begin
                    p_next      = cfg_data;
                    period_next = {1'b0, cfg_data};
                    lim_next    = (cfg_p_ext << 10) - (cfg_p_ext << 4) - (cfg_p_ext << 3);
                    div_req.start    = 1'b1;
                    div_req.dividend = {{(mplpi_pkg::DVD_W-P_W){1'b0}}, cfg_data};
                    div_req.divisor  = mplpi_pkg::GAIN_DIV;
                    state_next = mplpi_pkg::S_PRE400;
                end
                else if (in_fire)
                begin
                    err_next   = err_in;
                    state_next = mplpi_pkg::S_INTEG;
                end
            end
            mplpi_pkg::S_PRE400:
            begin
                if (div_rsp.done)
                begin
                    // a zero gain divisor is forced to one
                    kdiv_next = (quo[KDIV_W-1:0] == '0) ? KDIV_W'(1) : quo[KDIV_W-1:0];
                    div_req.start    = 1'b1;
                    div_req.dividend = {{(mplpi_pkg::DVD_W-P_W){1'b0}}, p_reg};
                    div_req.divisor  = mplpi_pkg::LIMIT_DIV;
                    state_next = mplpi_pkg::S_PRE120;
                end
            end
            mplpi_pkg::S_PRE120:
            begin
                if (div_rsp.done)
                begin
                    dlim_next  = quo[DLIM_W-1:0];
                    state_next = mplpi_pkg::S_IDLE;
                end
            end
            mplpi_pkg::S_INTEG:
            begin
                sum_next   = integ_reg - {{(INTEG_W-ERR_W){err_reg[ERR_W-1]}}, err_reg};
                state_next = mplpi_pkg::S_CLAMP;
            end
            mplpi_pkg::S_CLAMP:
            begin
                integ_next = over ? lim_s : (under ? nlim_s : sum_reg);
                if (cnt_inc == UE_C)
                begin
                    cnt_next = '0;
                    div_req.start    = 1'b1;
                    div_req.dividend = integ_abs;
                    div_req.divisor  = mplpi_pkg::INTEG_DIV;
                    state_next = mplpi_pkg::S_DIVI;
                end
                else
                begin
                    cnt_next   = cnt_inc;
                    upd_next   = 1'b0;
                    state_next = mplpi_pkg::S_RESULT;
                end
            end
            mplpi_pkg::S_DIVI:
            begin
                if (div_rsp.done)
                begin
                    q1_next = integ_reg[INTEG_W-1] ? -quo[Q1_W-1:0] : quo[Q1_W-1:0];
                    div_req.start    = 1'b1;
                    div_req.dividend = {{(mplpi_pkg::DVD_W-ERR_W){1'b0}}, err_abs};
                    div_req.divisor  = {{(mplpi_pkg::DVS_W-KDIV_W){1'b0}}, kdiv_reg};
                    state_next = mplpi_pkg::S_DIVE;
                end
            end
            mplpi_pkg::S_DIVE:
            begin
                if (div_rsp.done)
                begin
                    // proportional term carries the sign of minus the error
                    qe_next = err_reg[ERR_W-1] ? {1'b0, quo[QE_W-2:0]} : -{1'b0, quo[QE_W-2:0]};
                    div_req.start    = 1'b1;
                    div_req.dividend = {{(mplpi_pkg::DVD_W-Q1_W){1'b0}}, q1_abs};
                    div_req.divisor  = {{(mplpi_pkg::DVS_W-KDIV_W){1'b0}}, kdiv_reg};
                    state_next = mplpi_pkg::S_DIVQ;
                end
            end
            mplpi_pkg::S_DIVQ:
            begin
                if (div_rsp.done)
                begin
                    qq_next = q1_reg[Q1_W-1] ? -{1'b0, quo[QQ_W-2:0]} : {1'b0, quo[QQ_W-2:0]};
                    state_next = mplpi_pkg::S_SUM;
                end
            end
            mplpi_pkg::S_SUM:
            begin
                delta_next = {qe_reg[QE_W-1], qe_reg}
                           + {{(DELTA_W-QQ_W){qq_reg[QQ_W-1]}}, qq_reg};
                state_next = mplpi_pkg::S_LIMIT;
            end
            mplpi_pkg::S_LIMIT:
            begin
                period_next = period_sum[ADJ_W-1:0];
                upd_next    = 1'b1;
                state_next  = mplpi_pkg::S_RESULT;
            end
            mplpi_pkg::S_RESULT:
            begin
                if (res_ready)
                    state_next = mplpi_pkg::S_IDLE;
            end
            default:
            begin
                state_next = mplpi_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= mplpi_pkg::S_IDLE;
            p_reg      <= mplpi_pkg::PERIOD_RESET;
            period_reg <= {1'b0, mplpi_pkg::PERIOD_RESET};
            lim_reg    <= mplpi_pkg::LIM_RESET;
            kdiv_reg   <= mplpi_pkg::KDIV_RESET;
            dlim_reg   <= mplpi_pkg::DLIM_RESET;
            cnt_reg    <= '0;
            integ_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            p_reg      <= p_next;
            period_reg <= period_next;
            lim_reg    <= lim_next;
            kdiv_reg   <= kdiv_next;
            dlim_reg   <= dlim_next;
            cnt_reg    <= cnt_next;
            integ_reg  <= integ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg   <= err_next;
        sum_reg   <= sum_next;
        q1_reg    <= q1_next;
        qe_reg    <= qe_next;
        qq_reg    <= qq_next;
        delta_reg <= delta_next;
        upd_reg   <= upd_next;
    end

    `MPLPI_ASSERT_NXT(a_accept_integ, in_fire, state_reg == mplpi_pkg::S_INTEG, "accepted item did not enter integration")
    `MPLPI_ASSERT_IMP(a_done_expected, div_rsp.done, state_reg == mplpi_pkg::S_PRE400 || state_reg == mplpi_pkg::S_PRE120 || state_reg == mplpi_pkg::S_DIVI || state_reg == mplpi_pkg::S_DIVE || state_reg == mplpi_pkg::S_DIVQ, "divider finished outside a division step")

endmodule

FILE: rtl/core/mains_phase_lock_period_pi.sv
// Top level of the mains phase lock PI period adjuster.
// Each item is the timer count captured at a mains zero crossing; one result item follows
// with the folded phase error, an update flag and the current adjusted period. A crossing
// without a period update passes the integrate, clamp and result states into the output
// register. Every UPDATE_EVERY-th crossing runs three divisions through the shared divider,
// which yields one quotient bit per cycle over a 36-bit dividend. Writing the nominal period
// starts two more divisions (P/400 and P/120), during which no item is accepted. A finished
// result sits in the output register, so the next item can be accepted while it waits to be
// taken.
module mains_phase_lock_period_pi #(
    parameter int unsigned UPDATE_EVERY = 10
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [mplpi_pkg::P_W-1:0]             nominal_period_ticks,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [mplpi_pkg::CAPT_W-1:0]          captured_ticks,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [mplpi_pkg::ERR_W-1:0]    phase_error,
    output logic                                  period_updated,
    output logic [mplpi_pkg::ADJ_W-1:0]           adjusted_period
);

    mplpi_pkg::div_req_t div_req;
    mplpi_pkg::div_rsp_t div_rsp;
    mplpi_pkg::result_t  res;
    mplpi_pkg::result_t  out_reg, out_next;
    logic                res_valid;
    logic                res_ready;
    logic                out_valid_reg, out_valid_next;

    mplpi_serdiv u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    mplpi_seq #(
        .UPDATE_EVERY (UPDATE_EVERY)
    ) u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (nominal_period_ticks),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .capt      (captured_ticks),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .div_req   (div_req),
        .div_rsp   (div_rsp)
    );

    // take a new result when the output slot is empty or being drained
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid       = out_valid_reg;
    assign phase_error     = out_reg.phase_error;
    assign period_updated  = out_reg.period_updated;
    assign adjusted_period = out_reg.adjusted_period;

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench of the mains phase lock PI period adjuster.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned UPDATE_EVERY = 10;
    localparam longint     CAPT_MAX     = (64'd1 << mplpi_pkg::CAPT_W) - 1;
    localparam longint     PERIOD_MAX   = (64'd1 << mplpi_pkg::P_W) - 1;
    localparam longint     ADJ_MASK     = (64'd1 << mplpi_pkg::ADJ_W) - 1;
    localparam int         DRAIN_CYCLES = 200;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [mplpi_pkg::P_W-1:0]          nominal_period_ticks = '0;
    logic                               in_valid = 1'b0;
    logic                               in_ready;
    logic [mplpi_pkg::CAPT_W-1:0]       captured_ticks = '0;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    logic signed [mplpi_pkg::ERR_W-1:0] phase_error;
    logic                               period_updated;
    logic [mplpi_pkg::ADJ_W-1:0]        adjusted_period;

    // Predictor state
    longint nom_period;
    longint err_integral;
    int     crossing_cnt;
    longint held_period;

    logic [mplpi_pkg::CAPT_W-1:0] pending_captures[$];
    mplpi_pkg::result_t           expected_results[$];
    int                mismatches = 0;
    int                in_calm = 0;
    int                out_calm = 0;
    int                in_gap = 0;
    int                out_gap = 0;

    mains_phase_lock_period_pi #(
        .UPDATE_EVERY (UPDATE_EVERY)
    ) u_top (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .nominal_period_ticks (nominal_period_ticks),
        .in_valid             (in_valid),
        .in_ready             (in_ready),
        .captured_ticks       (captured_ticks),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .phase_error          (phase_error),
        .period_updated       (period_updated),
        .adjusted_period      (adjusted_period)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic mplpi_pkg::result_t predict_crossing(
        logic [mplpi_pkg::CAPT_W-1:0] capt);
        longint  p;
        longint  half;
        longint  err;
        longint  lim;
        longint  kdiv;
        longint  dlim;
        longint  delta;
        mplpi_pkg::result_t r;
        p = nom_period;
        half = p / 2;
        err = -longint'(capt);
        // fold once only
        if (err > half)
            err = err - p;
        else if (err < -half)
            err = err + p;
        lim = p * 1000;
        err_integral = err_integral - err;
        if (err_integral > lim)
            err_integral = lim;
        if (err_integral < -lim)
            err_integral = -lim;
        crossing_cnt = (crossing_cnt + 1) % UPDATE_EVERY;
        r.period_updated = 1'b0;
        if (crossing_cnt == 0)
        begin
            kdiv = p / 400;
            if (kdiv == 0)
                kdiv = 1;
            dlim = p / 120;
            delta = (-err) / kdiv + (err_integral / 1000) / kdiv;
            if (delta > dlim)
                delta = dlim;
            if (delta < -dlim)
                delta = -dlim;
            held_period = (p + delta) & ADJ_MASK;
            r.period_updated = 1'b1;
        end
        r.phase_error = err[mplpi_pkg::ERR_W-1:0];
        r.adjusted_period = held_period[mplpi_pkg::ADJ_W-1:0];
        return r;
    endfunction

    // Random idle gap between items, with the odd calm stretch of none at all
    function automatic int draw_gap(inout int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0)
        begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    function automatic logic [mplpi_pkg::CAPT_W-1:0] rand_capture(longint p);
        int     sel;
        longint v;
        longint w;
        sel = $urandom_range(0, 9);
        w = p / 8;
        if (w > 5000)
            w = 5000;
        case (sel)
            0, 1, 2, 3, 4: v = p + longint'($urandom_range(0, 2 * w)) - w;
            5:             v = longint'($urandom_range(0, 2000));
            6:             v = p / 2 + longint'($urandom_range(0, 6)) - 3;
            7:             v = longint'($urandom) & CAPT_MAX;
            8:             v = p + p / 2 + longint'($urandom_range(0, 6)) - 3;
            default:       v = $urandom_range(0, 1) ? CAPT_MAX : 0;
        endcase
        if (v < 0)
            v = 0;
        if (v > CAPT_MAX)
            v = CAPT_MAX;
        return v[mplpi_pkg::CAPT_W-1:0];
    endfunction

    // Input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            captured_ticks <= '0;
            in_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_results.push_back(predict_crossing(captured_ticks));
                in_gap = draw_gap(in_calm);
            end
            if (!in_valid || in_ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_captures.size() > 0)
                begin
                    in_valid <= 1'b1;
                    captured_ticks <= pending_captures.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor
    always @(posedge clk or negedge rst_n)
    begin
        mplpi_pkg::result_t exp_r;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_gap = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result item: phase_error %0d", phase_error);
                    mismatches++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (phase_error !== exp_r.phase_error)
                    begin
                        $error("phase_error: expected %0d, actual %0d",
                               exp_r.phase_error, phase_error);
                        mismatches++;
                    end
                    if (period_updated !== exp_r.period_updated)
                    begin
                        $error("period_updated: expected %0d, actual %0d",
                               exp_r.period_updated, period_updated);
                        mismatches++;
                    end
                    if (adjusted_period !== exp_r.adjusted_period)
                    begin
                        $error("adjusted_period: expected %0d, actual %0d",
                               exp_r.adjusted_period, adjusted_period);
                        mismatches++;
                    end
                end
                out_gap = draw_gap(out_calm);
            end
            if (!out_ready || out_valid)
            begin
                if (out_gap > 0)
                begin
                    out_gap--;
                    out_ready <= 1'b0;
                end
                else
                    out_ready <= 1'b1;
            end
        end
    end

    task automatic wait_drained();
        while (pending_captures.size() > 0 || expected_results.size() > 0 || in_valid)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Load a new nominal period; only called once the block is idle
    task automatic write_period(longint value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        nominal_period_ticks <= value[mplpi_pkg::P_W-1:0];
        // sample ready away from the edge, then drop valid after the accepting edge
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        nom_period = value;
        held_period = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_random(longint p, int count);
        repeat (count) pending_captures.push_back(rand_capture(p));
    endtask

    function automatic longint rand_period();
        case ($urandom_range(0, 3))
            0, 1:    return longint'($urandom_range(400, 200000));
            2:       return longint'($urandom_range(400, PERIOD_MAX));
            default: return longint'($urandom_range(158000, 162000));
        endcase
    endfunction

    initial
    begin
        longint p;
        nom_period = mplpi_pkg::PERIOD_RESET;
        held_period = mplpi_pkg::PERIOD_RESET;
        err_integral = 0;
        crossing_cnt = 0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset period: both sides of the fold thresholds and field extremes
        p = mplpi_pkg::PERIOD_RESET;
        pending_captures = {25'd0, 25'd1, 25'd79999, 25'd80000, 25'd80001, 25'd159999,
                            25'd160000, 25'd160001, 25'd240000, 25'd240001, 25'h1FFFFFF,
                            25'h1000000, 25'h0AAAAAA, 25'h1555555, 25'd100, 25'd160100,
                            25'd160000, 25'd159990, 25'd240002, 25'd0};
        queue_random(p, 150);
        wait_drained();

        // Largest period: push the integral negative, then shrink the limit under it
        p = PERIOD_MAX;
        write_period(p);
        pending_captures = {25'd8388607, 25'd8388608, 25'd16777215, 25'd25165822,
                            25'd25165823, 25'h1FFFFFF, 25'd0};
        repeat (110) pending_captures.push_back(25'd8388608 + 25'($urandom_range(0, 3)));
        queue_random(p, 150);
        wait_drained();

        // Smallest period: both integral clamps and the delta clamp
        p = 400;
        write_period(p);
        pending_captures = {25'd0, 25'd199, 25'd200, 25'd201, 25'd399, 25'd400, 25'd401,
                            25'd600, 25'd601, 25'h1FFFFFF};
        queue_random(p, 200);
        wait_drained();

        repeat (5)
        begin
            p = rand_period();
            write_period(p);
            queue_random(p, 200);
            wait_drained();
        end

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
